/* rtl/bsseg_pkg.sv */
// Package for the binary to seven-segment display block.
// Holds digit count, saturation limit, divide-by-ten constants, cell word type
// and the segment pattern function. No dependencies.
package bsseg_pkg;

    localparam int unsigned DIGIT_COUNT = 6;
    localparam int unsigned OUT_FIELDS  = 6;
    localparam int unsigned MAX_VALUE   = 10 ** DIGIT_COUNT - 1;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned MASK_W  = 6;
    localparam int unsigned SEG_W   = 8;
    localparam int unsigned REST_W  = 20;
    localparam int unsigned DIGIT_W = 4;

    localparam int unsigned DIV_SHIFT = 23;
    localparam int unsigned RECIP_W   = 20;
    localparam int unsigned PROD_W    = REST_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV10_RECIP = RECIP_W'(838861);

    localparam logic [SEG_W-1:0] POINT_BIT = 8'h80;

    typedef logic [DIGIT_COUNT-1:0][SEG_W-1:0] t_segs;

    typedef struct packed {
        logic [REST_W-1:0] rest;
        logic [MASK_W-1:0] mask;
        logic              keep_zeros;
        t_segs             segs;
    } t_word;

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'b0011_1111;
            4'd1:    s = 8'b0000_0110;
            4'd2:    s = 8'b0101_1011;
            4'd3:    s = 8'b0100_1111;
            4'd4:    s = 8'b0110_0110;
            4'd5:    s = 8'b0110_1101;
            4'd6:    s = 8'b0111_1101;
            4'd7:    s = 8'b0000_0111;
            4'd8:    s = 8'b0111_1111;
            4'd9:    s = 8'b0110_1111;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

/* rtl/binary_to_seven_segment_display.sv */
// Top level of the binary to seven-segment display block.
// Saturates the input, then runs it through a chain of bsseg_cell digit cells.
// Depends on bsseg_pkg and bsseg_cell.
//
//  channel  | dir | fields (lowest bit up)
//  s_axis   | in  | tdata: value[31:0], point_mask[37:32]; tuser: show_leading_zeros
//  m_axis   | out | tdata: seg_pos0 .. seg_pos5, 8 bits each
//
// One word enters per cycle while m_axis is not stalled; each digit cell adds one register.
// The last cell's register is the output register; each cell holds its word
// while the next one is full and stalled, and empty cells keep taking input.
// Reset clears the valid bits of all cells.
module binary_to_seven_segment_display (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], point_mask[37:32], zero pad
    input  logic [0:0]  s_axis_tuser,   // show_leading_zeros
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // seg_pos0[7:0] .. seg_pos5[47:40]
);

    localparam int unsigned N = bsseg_pkg::DIGIT_COUNT;

    logic [bsseg_pkg::VALUE_W-1:0] value;
    logic [bsseg_pkg::REST_W-1:0]  clamped;
    bsseg_pkg::t_word              head;
    bsseg_pkg::t_word              words [N+1];
    logic [N:0]                    valid;
    logic [N:0]                    ready;

    assign value = s_axis_tdata[bsseg_pkg::VALUE_W-1:0];

    always_comb begin
        priority if (value[bsseg_pkg::VALUE_W-1]) begin
            clamped = '0;
        end else if (value > bsseg_pkg::VALUE_W'(bsseg_pkg::MAX_VALUE)) begin
            clamped = bsseg_pkg::REST_W'(bsseg_pkg::MAX_VALUE);
        end else begin
            clamped = value[bsseg_pkg::REST_W-1:0];
        end
        head.rest       = clamped;
        head.mask       = s_axis_tdata[bsseg_pkg::VALUE_W +: bsseg_pkg::MASK_W];
        head.keep_zeros = s_axis_tuser[0];
        head.segs       = '0;
    end

    assign words[0]      = head;
    assign valid[0]      = s_axis_tvalid;
    assign s_axis_tready = ready[0];
    assign ready[N]      = m_axis_tready;
    assign m_axis_tvalid = valid[N];

    for (genvar k = 0; k < N; k++) begin : g_cell
        bsseg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lsd   (k == 0),
            .i_valid (valid[k]),
            .i_word  (words[k]),
            .i_ready (ready[k+1]),
            .o_ready (ready[k]),
            .o_valid (valid[k+1]),
            .o_word  (words[k+1])
        );
    end

    for (genvar p = 0; p < bsseg_pkg::OUT_FIELDS; p++) begin : g_out
        if (p < N) begin : g_used
            assign m_axis_tdata[p*bsseg_pkg::SEG_W +: bsseg_pkg::SEG_W] = words[N].segs[p];
        end else begin : g_unused
            assign m_axis_tdata[p*bsseg_pkg::SEG_W +: bsseg_pkg::SEG_W] = '0;
        end
    end

endmodule

/* rtl/bsseg_cell.sv */
// One digit cell: peels the lowest decimal digit off the remaining value,
// encodes it and hands the word to the next cell. Depends on bsseg_pkg.
module bsseg_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_lsd,
    input  logic             i_valid,
    input  bsseg_pkg::t_word i_word,
    input  logic             i_ready,
    output logic             o_ready,
    output logic             o_valid,
    output bsseg_pkg::t_word o_word
);

    logic                            r_valid;
    bsseg_pkg::t_word                r_word;
    bsseg_pkg::t_word                n_word;
    logic [bsseg_pkg::PROD_W-1:0]    prod;
    logic [bsseg_pkg::REST_W-1:0]    quot;
    logic [bsseg_pkg::REST_W-1:0]    times10;
    logic [bsseg_pkg::REST_W-1:0]    remv;
    logic [bsseg_pkg::SEG_W-1:0]     seg;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        prod    = bsseg_pkg::PROD_W'(i_word.rest) * bsseg_pkg::PROD_W'(bsseg_pkg::DIV10_RECIP);
        quot    = bsseg_pkg::REST_W'(prod >> bsseg_pkg::DIV_SHIFT);
        times10 = (quot << 3) + (quot << 1);
        remv    = i_word.rest - times10;
        seg     = bsseg_pkg::seg_of(remv[bsseg_pkg::DIGIT_W-1:0]);
        if (i_word.mask[0]) begin
            seg = seg | bsseg_pkg::POINT_BIT;
        end
        if (!i_word.keep_zeros && !i_lsd && (i_word.rest == '0)) begin
            seg = '0;
        end
        n_word.rest       = quot;
        n_word.mask       = i_word.mask >> 1;
        n_word.keep_zeros = i_word.keep_zeros;
        n_word.segs       = {i_word.segs[bsseg_pkg::DIGIT_COUNT-2:0], seg};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= n_word;
        end
    end

endmodule
